/* rtl/spr_pkg.sv */
`default_nettype none

package spr_pkg;

   // Field widths fixed by the stream format
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int WORD_W      = 64;

   // Longest result burst one item can cause (replacement or full window)
   localparam int BURST_BYTES = 8;
   localparam int BURST_W     = BURST_BYTES * BYTE_W;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES     = 2'd0,
      CSR_PATTERN_LEN       = 2'd1,
      CSR_REPLACEMENT_BYTES = 2'd2,
      CSR_REPLACEMENT_LEN   = 2'd3
   } csr_addr_type;

endpackage

`default_nettype wire

/* rtl/spr_intf.sv */
`default_nettype none

// Input byte channel
interface spr_req_if;
   logic                         valid;
   logic                         ready;
   logic [spr_pkg::BYTE_W-1:0]   data_byte;
   logic                         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Rewritten byte channel
interface spr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spr_pkg::BYTE_W-1:0]   out_byte;
   logic                         byte_valid;
   logic                         out_last;
   logic                         config_invalid;

   modport source (output valid, output out_byte, output byte_valid, output out_last,
                   output config_invalid, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                   input config_invalid, output ready);
endinterface

// Register write channel
interface spr_csr_if;
   logic                         valid;
   logic                         ready;
   spr_pkg::csr_addr_type        addr;
   logic [spr_pkg::WORD_W-1:0]   data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/stream_pattern_replace.sv */
// Streaming search and replace on a byte stream.
// req_ch carries one byte per item with a last marker; rsp_ch returns the
// rewritten stream, one byte per item, with byte_valid, out_last and
// config_invalid. csr_ch writes the pattern, pattern length, replacement and
// replacement length; it is always ready. The user must write it only while
// idle; the block does not enforce this. Writing the pattern length drops
// any pending window bytes. Each accepted byte enters a window of up to
// MAX_PATTERN bytes that is compared with the pattern in parallel in the
// accepting cycle. Results (0 to 8 per item) are loaded into a burst register
// and shown from the next cycle on, one per cycle while rsp_ch is ready. An
// item causing at most one result sustains one byte per cycle while rsp_ch is
// ready; an item causing more results holds the burst register until they
// drain, and the next item is taken in the cycle its last result leaves.
// A final byte that leaves nothing to emit yields one bare end marker.
// When rsp_ch stalls the burst holds and req_ch ready drops once it is full.
// Reset restores pattern length 1, empty replacement and an empty window.
`default_nettype none

module stream_pattern_replace #(
   parameter int MAX_PATTERN = 8
) (
   input  wire         clock,
   input  wire         reset,
   spr_req_if.sink     req_ch,
   spr_rsp_if.source   rsp_ch,
   spr_csr_if.sink     csr_ch
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int LW    = spr_pkg::LEN_W;
   localparam int BW    = spr_pkg::BYTE_W;
   localparam int BSTW  = spr_pkg::BURST_W;
   localparam logic [LW-1:0] MAX_P_LEN = LW'(MAX_PATTERN);
   localparam logic [LW-1:0] MAX_R_LEN = LW'(spr_pkg::BURST_BYTES);

   // Configuration registers
   logic [spr_pkg::WORD_W-1:0] pat_bytes_ff, repl_bytes_ff;
   logic [LW-1:0]              pat_len_ff, repl_len_ff;

   // Window state
   logic [BW-1:0]    win_ff [MAX_PATTERN];
   logic [BW-1:0]    win_in [MAX_PATTERN];
   logic [CNT_W-1:0] win_cnt_ff, win_cnt_in;

   // Burst register
   logic                        bst_active_ff;
   logic [spr_pkg::BURST_W-1:0] bst_bytes_ff;
   logic [LW-1:0]               bst_rem_ff;
   logic                        bst_last_ff, bst_inv_ff, bst_bare_ff;

   // Per-item decode
   logic [LW-1:0]               p_eff, r_eff, load_len;
   logic [CNT_W-1:0]            eff_cnt, cnt_new;
   logic [BW-1:0]               win_new [MAX_PATTERN];
   logic [spr_pkg::BURST_W-1:0] win_flat, load_bytes;
   logic                        full, match, load, load_inv, load_bare;
   logic                        accept, take;

   assign take   = bst_active_ff && rsp_ch.ready;
   assign req_ch.ready = !bst_active_ff || (bst_rem_ff == LW'(1) && rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign p_eff = (pat_len_ff > MAX_P_LEN) ? MAX_P_LEN : pat_len_ff;
   assign r_eff = (repl_len_ff > MAX_R_LEN) ? MAX_R_LEN : repl_len_ff;

   // Insert the new byte, compare the window and pick the burst source
   always_comb begin
      eff_cnt = (LW'(win_cnt_ff) >= p_eff) ? '0 : win_cnt_ff;
      cnt_new = eff_cnt + CNT_W'(1);
      full    = (LW'(cnt_new) == p_eff);
      match   = 1'b1;
      win_flat = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_new[i] = (CNT_W'(i) == eff_cnt) ? req_ch.data_byte : win_ff[i];
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_flat[i*BW +: BW] = win_new[i];
         if (LW'(i) < p_eff && win_new[i] != pat_bytes_ff[i*BW +: BW]) begin
            match = 1'b0;
         end
      end

      win_in     = win_new;
      win_cnt_in = cnt_new;
      load_bytes = win_flat;
      load_len   = '0;
      load_inv   = 1'b0;

      priority if (pat_len_ff == '0) begin
         // Invalid pattern length: pass the byte through, window untouched
         win_in     = win_ff;
         win_cnt_in = win_cnt_ff;
         load_bytes = BSTW'(req_ch.data_byte);
         load_len   = LW'(1);
         load_inv   = 1'b1;
      end else if (full && match) begin
         load_bytes = repl_bytes_ff;
         load_len   = r_eff;
         win_cnt_in = '0;
      end else if (full && req_ch.last_byte) begin
         load_len   = p_eff;
         win_cnt_in = '0;
      end else if (full) begin
         // Emit the oldest byte and shift the window
         load_len   = LW'(1);
         win_cnt_in = CNT_W'(p_eff - LW'(1));
         for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            win_in[i] = win_new[i+1];
         end
      end else if (req_ch.last_byte) begin
         load_len   = LW'(cnt_new);
         win_cnt_in = '0;
      end else begin
         load_len   = '0;
      end

      load_bare = req_ch.last_byte && (load_len == '0);
      if (load_bare) begin
         load_bytes = '0;
      end
      load = (load_len != '0) || load_bare;
   end

   // Configuration registers and window count
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff  <= '0;
         pat_len_ff    <= LW'(1);
         repl_bytes_ff <= '0;
         repl_len_ff   <= '0;
         win_cnt_ff    <= '0;
      end else begin
         // A pattern length write drops the pending window
         if (csr_ch.valid && csr_ch.addr == spr_pkg::CSR_PATTERN_LEN) begin
            win_cnt_ff <= '0;
         end else if (accept) begin
            win_cnt_ff <= win_cnt_in;
         end
         if (csr_ch.valid) begin
            unique case (csr_ch.addr)
               spr_pkg::CSR_PATTERN_BYTES:     pat_bytes_ff  <= csr_ch.data;
               spr_pkg::CSR_PATTERN_LEN:       pat_len_ff    <= csr_ch.data[LW-1:0];
               spr_pkg::CSR_REPLACEMENT_BYTES: repl_bytes_ff <= csr_ch.data;
               spr_pkg::CSR_REPLACEMENT_LEN:   repl_len_ff   <= csr_ch.data[LW-1:0];
               default: ;
            endcase
         end
      end
   end

   // Window bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   // Burst control: reload on an item with results, else drain on take
   always_ff @(posedge clock) begin
      if (reset) begin
         bst_active_ff <= 1'b0;
         bst_rem_ff    <= '0;
      end else begin
         if (accept && load) begin
            bst_active_ff <= 1'b1;
            bst_rem_ff    <= load_bare ? LW'(1) : load_len;
         end else if (take) begin
            bst_rem_ff <= bst_rem_ff - LW'(1);
            if (bst_rem_ff == LW'(1)) begin
               bst_active_ff <= 1'b0;
            end
         end
      end
   end

   // Burst payload
   always_ff @(posedge clock) begin
      if (accept && load) begin
         bst_bytes_ff <= load_bytes;
         bst_last_ff  <= req_ch.last_byte;
         bst_inv_ff   <= load_inv;
         bst_bare_ff  <= load_bare;
      end else if (take) begin
         bst_bytes_ff <= bst_bytes_ff >> BW;
      end
   end

   assign rsp_ch.valid          = bst_active_ff;
   assign rsp_ch.out_byte       = bst_bytes_ff[BW-1:0];
   assign rsp_ch.byte_valid     = !bst_bare_ff;
   assign rsp_ch.out_last       = bst_last_ff && (bst_rem_ff == LW'(1));
   assign rsp_ch.config_invalid = bst_inv_ff;

   // Checks
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      bst_active_ff |-> bst_rem_ff != '0)
      else $error("active burst with no bytes left");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && bst_active_ff) |-> (take && bst_rem_ff == LW'(1)))
      else $error("item accepted over a burst still in flight");

   a_win_cnt: assert property (@(posedge clock) disable iff (reset)
      LW'(win_cnt_ff) < MAX_P_LEN)
      else $error("window count reached pattern limit");

   a_bare_single: assert property (@(posedge clock) disable iff (reset)
      (bst_active_ff && bst_bare_ff) |-> (bst_last_ff && bst_rem_ff == LW'(1)))
      else $error("bare end marker not a single final result");

   a_inv_single: assert property (@(posedge clock) disable iff (reset)
      (bst_active_ff && bst_inv_ff) |-> bst_rem_ff == LW'(1))
      else $error("pass-through item produced more than one result");

endmodule

`default_nettype wire

/* sim/tb_stream_pattern_replace.sv */
module tb_stream_pattern_replace;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAT       = 8;
   localparam int MAX_REP       = 8;
   localparam int STALL_PCT     = 30;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_ITEMS   = 37;

   // One item of the rewritten stream
   typedef struct packed {
      logic [spr_pkg::BYTE_W-1:0] out_byte;
      logic                       byte_valid;
      logic                       out_last;
      logic                       config_invalid;
   } rewrite_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One line of the directed sequence: a byte or a register write
   typedef struct {
      row_kind_type               kind;
      spr_pkg::csr_addr_type      addr;
      logic [spr_pkg::WORD_W-1:0] wdata;
      logic [spr_pkg::BYTE_W-1:0] data_byte;
      logic                       last_byte;
      logic                       typed;
      rewrite_type                want;
   } stim_row_type;

   logic clock;
   logic reset;
   bit   stall_on = 1'b1;
   int   fails    = 0;
   int   quiet    = 0;

   rewrite_type  expected_q[$];
   rewrite_type  burst_q[$];
   stim_row_type stim_rows[$];

   // Shadow copy of the registers and the match window
   logic [spr_pkg::WORD_W-1:0] pat_bytes;
   logic [spr_pkg::LEN_W-1:0]  pat_len;
   logic [spr_pkg::WORD_W-1:0] rep_bytes;
   logic [spr_pkg::LEN_W-1:0]  rep_len;
   logic [spr_pkg::BYTE_W-1:0] win [MAX_PAT];
   int                         win_cnt;

   spr_req_if req_ch();
   spr_rsp_if rsp_ch();
   spr_csr_if csr_ch();

   stream_pattern_replace #(
      .MAX_PATTERN(MAX_PAT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Track a register write in the shadow copy
   function automatic void apply_csr(spr_pkg::csr_addr_type addr,
                                     logic [spr_pkg::WORD_W-1:0] wdata);
      case (addr)
         spr_pkg::CSR_PATTERN_BYTES: begin
            pat_bytes = wdata;
         end
         spr_pkg::CSR_PATTERN_LEN: begin
            pat_len = wdata[spr_pkg::LEN_W-1:0];
            win_cnt = 0;
         end
         spr_pkg::CSR_REPLACEMENT_BYTES: begin
            rep_bytes = wdata;
         end
         default: begin
            rep_len = wdata[spr_pkg::LEN_W-1:0];
         end
      endcase
   endfunction

   // Work out the rewritten items caused by one input byte into burst_q
   function automatic void predict_rewrite(logic [spr_pkg::BYTE_W-1:0] b, logic last);
      int          p;
      int          r;
      int          i;
      logic        hit;
      rewrite_type tail;
      burst_q.delete();
      if (pat_len == 0) begin
         burst_q.push_back(rewrite_type'{b, 1'b1, last, 1'b1});
         return;
      end
      p = (pat_len > MAX_PAT) ? MAX_PAT : int'(pat_len);
      r = (rep_len > MAX_REP) ? MAX_REP : int'(rep_len);
      win[win_cnt] = b;
      win_cnt++;
      // Full window: swap in the replacement or release the oldest byte
      if (win_cnt == p) begin
         hit = 1'b1;
         for (i = 0; i < p; i++) begin
            if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < r; i++) begin
               burst_q.push_back(rewrite_type'{rep_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0});
            end
            win_cnt = 0;
         end else begin
            burst_q.push_back(rewrite_type'{win[0], 1'b1, 1'b0, 1'b0});
            for (i = 1; i < p; i++) win[i-1] = win[i];
            win_cnt = p - 1;
         end
      end
      // End of stream: flush the window, mark the final item
      if (last) begin
         for (i = 0; i < win_cnt; i++) begin
            burst_q.push_back(rewrite_type'{win[i], 1'b1, 1'b0, 1'b0});
         end
         win_cnt = 0;
         if (burst_q.size() == 0) burst_q.push_back(rewrite_type'{8'h00, 1'b0, 1'b0, 1'b0});
         tail = burst_q.pop_back();
         tail.out_last = 1'b1;
         burst_q.push_back(tail);
      end
   endfunction

   function automatic stim_row_type byte_row(logic [spr_pkg::BYTE_W-1:0] b, logic last,
                                             logic typed = 1'b0, rewrite_type want = '0);
      stim_row_type row;
      row.kind      = ROW_BYTE;
      row.addr      = spr_pkg::CSR_PATTERN_BYTES;
      row.wdata     = '0;
      row.data_byte = b;
      row.last_byte = last;
      row.typed     = typed;
      row.want      = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(spr_pkg::csr_addr_type addr,
                                            logic [spr_pkg::WORD_W-1:0] wdata);
      stim_row_type row;
      row           = byte_row(8'h00, 1'b0);
      row.kind      = ROW_CSR;
      row.addr      = addr;
      row.wdata     = wdata;
      return row;
   endfunction

   function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endfunction

   task automatic check_rewrite();
      rewrite_type got;
      rewrite_type want;
      got = '{rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.out_last, rsp_ch.config_invalid};
      if (expected_q.size() == 0) begin
         $error("unexpected item: out_byte %0h byte_valid %0b out_last %0b config_invalid %0b",
                got.out_byte, got.byte_valid, got.out_last, got.config_invalid);
         fails++;
      end else begin
         want = expected_q.pop_front();
         cmp_field("out_byte", want.out_byte, got.out_byte);
         cmp_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
         cmp_field("out_last", 8'(want.out_last), 8'(got.out_last));
         cmp_field("config_invalid", 8'(want.config_invalid), 8'(got.config_invalid));
      end
   endtask

   // Drop valid, let every expected item drain, then allow the pipe to settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(spr_pkg::csr_addr_type addr, logic [spr_pkg::WORD_W-1:0] wdata);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= addr;
      csr_ch.data  <= wdata;
      do @(posedge clock); while (!csr_ch.ready);
      apply_csr(addr, wdata);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one byte, after a random gap while stalls are on; hold it until taken
   task automatic send_byte(logic [spr_pkg::BYTE_W-1:0] b, logic last, logic typed,
                            rewrite_type want);
      while (stall_on && $urandom_range(0, 99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      predict_rewrite(b, last);
      if (typed) expected_q.push_back(want);
      else foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Result side: check accepted items, stall at random
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_rewrite();
         rsp_ch.ready <= !reset && !(stall_on && $urandom_range(0, 99) < STALL_PCT);
      end
   end

   // Watchdog: give up after a long run of cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int                         ph;
      int                         k;
      int                         j;
      int                         n;
      int                         bad;
      int                         sent;
      int                         roll;
      int                         pl;
      int                         first;
      logic [spr_pkg::LEN_W-1:0]  plen;
      logic [spr_pkg::LEN_W-1:0]  rlen;
      logic [spr_pkg::WORD_W-1:0] pbytes;
      logic [spr_pkg::WORD_W-1:0] rbytes;
      logic [spr_pkg::WORD_W-1:0] wdata;
      logic [spr_pkg::BYTE_W-1:0] b;
      logic [spr_pkg::BYTE_W-1:0] sym0;
      logic [spr_pkg::BYTE_W-1:0] sym1;
      logic                       two_sym;
      spr_pkg::csr_addr_type      addr;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.addr      <= spr_pkg::CSR_PATTERN_BYTES;
      csr_ch.data      <= '0;

      pat_bytes = '0;
      pat_len   = 4'd1;
      rep_bytes = '0;
      rep_len   = 4'd0;
      win_cnt   = 0;
      foreach (win[i]) win[i] = '0;

      // Reset state: one-byte pattern 00 deleted, anything else passes
      stim_rows.push_back(byte_row(8'hFF, 1'b0, 1'b1, rewrite_type'{8'hFF, 1'b1, 1'b0, 1'b0}));
      stim_rows.push_back(byte_row(8'h00, 1'b0));
      stim_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, rewrite_type'{8'h00, 1'b0, 1'b1, 1'b0}));
      stim_rows.push_back(byte_row(8'h80, 1'b1, 1'b1, rewrite_type'{8'h80, 1'b1, 1'b1, 1'b0}));
      // Zero pattern length: pass through with the invalid flag
      stim_rows.push_back(csr_row(spr_pkg::CSR_PATTERN_LEN, 64'd0));
      stim_rows.push_back(byte_row(8'hA5, 1'b0, 1'b1, rewrite_type'{8'hA5, 1'b1, 1'b0, 1'b1}));
      stim_rows.push_back(byte_row(8'h5A, 1'b1, 1'b1, rewrite_type'{8'h5A, 1'b1, 1'b1, 1'b1}));
      // Oversized lengths act as eight: full pattern, full replacement burst
      stim_rows.push_back(csr_row(spr_pkg::CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
      stim_rows.push_back(csr_row(spr_pkg::CSR_PATTERN_LEN, 64'd15));
      stim_rows.push_back(csr_row(spr_pkg::CSR_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF));
      stim_rows.push_back(csr_row(spr_pkg::CSR_REPLACEMENT_LEN, 64'd15));
      for (j = 0; j < 8; j++) stim_rows.push_back(byte_row(8'hFF, 1'b0));
      stim_rows.push_back(byte_row(8'hFF, 1'b0));
      stim_rows.push_back(byte_row(8'hFF, 1'b1));
      // Length write with bytes pending drops the window
      stim_rows.push_back(byte_row(8'h11, 1'b0));
      stim_rows.push_back(byte_row(8'h22, 1'b0));
      stim_rows.push_back(csr_row(spr_pkg::CSR_PATTERN_BYTES, 64'h2211));
      stim_rows.push_back(csr_row(spr_pkg::CSR_PATTERN_LEN, 64'd2));
      stim_rows.push_back(csr_row(spr_pkg::CSR_REPLACEMENT_LEN, 64'd0));
      stim_rows.push_back(byte_row(8'h22, 1'b1, 1'b1, rewrite_type'{8'h22, 1'b1, 1'b1, 1'b0}));
      // Final byte completes a deleted match: bare end marker
      stim_rows.push_back(byte_row(8'h11, 1'b0));
      stim_rows.push_back(byte_row(8'h22, 1'b1, 1'b1, rewrite_type'{8'h00, 1'b0, 1'b1, 1'b0}));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(stim_rows[i].addr, stim_rows[i].wdata);
         end else begin
            send_byte(stim_rows[i].data_byte, stim_rows[i].last_byte, stim_rows[i].typed,
                      stim_rows[i].want);
         end
      end

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         // Run a few phases with no idling on either side
         stall_on = (ph < 5 || ph > 7);

         case ($urandom_range(0, 9))
            0:       plen = 4'd0;
            1:       plen = 4'($urandom_range(MAX_PAT + 1, 15));
            default: plen = 4'($urandom_range(1, MAX_PAT));
         endcase
         rlen    = 4'($urandom_range(0, 15));
         two_sym = 1'($urandom_range(0, 1));
         sym0    = 8'($urandom);
         sym1    = 8'($urandom);
         pbytes  = {$urandom, $urandom};
         rbytes  = {$urandom, $urandom};
         // Two-symbol patterns give self-overlapping matches
         if (two_sym) begin
            for (j = 0; j < 8; j++) pbytes[8*j +: 8] = $urandom_range(0, 1) ? sym0 : sym1;
         end

         // Write all registers, starting at a random one
         wait_idle();
         first = $urandom_range(0, 3);
         for (k = 0; k < 4; k++) begin
            addr = spr_pkg::csr_addr_type'(2'((first + k) % 4));
            case (addr)
               spr_pkg::CSR_PATTERN_BYTES:     wdata = pbytes;
               spr_pkg::CSR_PATTERN_LEN:       wdata = spr_pkg::WORD_W'(plen);
               spr_pkg::CSR_REPLACEMENT_BYTES: wdata = rbytes;
               default:                        wdata = spr_pkg::WORD_W'(rlen);
            endcase
            write_csr(addr, wdata);
         end

         pl = (plen == 0) ? 1 : ((plen > MAX_PAT) ? MAX_PAT : int'(plen));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               // Pattern copy, now and then cut short or with one bit flipped
               n   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, pl) : pl;
               bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
               for (j = 0; j < n; j++) begin
                  b = pbytes[8*j +: 8];
                  if (j == bad) b = b ^ 8'(1 << $urandom_range(0, 7));
                  send_byte(b, $urandom_range(0, 11) == 0, 1'b0, '0);
                  sent++;
               end
            end else begin
               if (roll < 85 && two_sym) b = $urandom_range(0, 1) ? sym0 : sym1;
               else if (roll < 85) b = pbytes[8*$urandom_range(0, 7) +: 8];
               else b = 8'($urandom);
               send_byte(b, $urandom_range(0, 11) == 0, 1'b0, '0);
               sent++;
            end
         end
      end

      stall_on = 1'b1;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
